// File: sv/fcms_pkg.sv
// ----------------------------------------------------------------------------
// fcms_pkg
// shared constants, types and hash helpers of the flow count-min sketch update
// ----------------------------------------------------------------------------
package fcms_pkg;

    localparam int ROWS      = 4;
    localparam int ROW_WIDTH = 1024;

    localparam int ROW_IDX_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int BKT_W     = (ROW_WIDTH > 1) ? $clog2(ROW_WIDTH) : 1;
    localparam int ADDR_W    = $clog2(ROWS * ROW_WIDTH);
    localparam int DEPTH     = ROWS * ROW_WIDTH;

    localparam logic [31:0] HASH_SEED = 32'd5381;
    localparam logic [7:0]  PROTO_TCP = 8'd6;
    localparam logic [7:0]  PROTO_UDP = 8'd17;

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef logic [ROW_IDX_W-1:0] row_t;

    typedef struct packed {
        logic [3:0]  row_number;
        logic [15:0] bucket_index;
        logic [31:0] new_count;
        logic        last_row;
    } result_t;

    function automatic logic [31:0] djb2_step(input logic [31:0] h, input logic [7:0] b);
        djb2_step = (h << 5) + h + {24'd0, b};
    endfunction

    function automatic logic [31:0] hash_head(input logic [31:0] h, input logic [55:0] d);
        logic [31:0] acc;
        acc = h;
        for (int i = 0; i < 7; i++)
        begin
            acc = djb2_step(acc, d[55 - 8*i -: 8]);
        end
        hash_head = acc;
    endfunction

    function automatic logic [31:0] hash_tail(input logic [31:0] h, input logic [47:0] d);
        logic [31:0] acc;
        acc = h;
        for (int i = 0; i < 6; i++)
        begin
            acc = djb2_step(acc, d[47 - 8*i -: 8]);
        end
        hash_tail = acc;
    endfunction

endpackage

// File: sv/fcms_front.sv
// ----------------------------------------------------------------------------
// fcms_front
// accepts flow tuples, drops non-ipv4 and non tcp/udp items, hashes the common key bytes
// ----------------------------------------------------------------------------
module fcms_front
    import fcms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        is_ipv4,
    input  logic [31:0] src_addr,
    input  logic [31:0] dst_addr,
    input  logic [15:0] src_port_num,
    input  logic [15:0] dst_port_num,
    input  logic [7:0]  ip_proto,
    input  logic        busy,
    output logic        hash_valid,
    input  logic        hash_ready,
    output logic [31:0] hash_data
);

    logic        s1_v_reg, s1_v_next;
    logic        s2_v_reg, s2_v_next;
    logic [31:0] s1_h_reg;
    logic [47:0] s1_tail_reg;
    logic [31:0] s2_h_reg;
    logic        keep, accept, s1_adv, s2_adv;

    assign keep   = is_ipv4 && ((ip_proto == PROTO_TCP) || (ip_proto == PROTO_UDP));
    assign s2_adv = s2_v_reg && hash_ready;
    assign s1_adv = s1_v_reg && (!s2_v_reg || s2_adv);
    assign full   = busy || (s1_v_reg && !s1_adv);
    assign accept = push && !full;

    always_comb
    begin
        s1_v_next = s1_v_reg;
        if (accept && keep)
        begin
            s1_v_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_v_next = 1'b0;
        end
        s2_v_next = s2_v_reg;
        if (s1_adv)
        begin
            s2_v_next = 1'b1;
        end
        else if (s2_adv)
        begin
            s2_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= s1_v_next;
            s2_v_reg <= s2_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && keep)
        begin
            s1_h_reg    <= hash_head(HASH_SEED, {src_addr, dst_addr[31:8]});
            s1_tail_reg <= {dst_addr[7:0], src_port_num, dst_port_num, ip_proto};
        end
        if (s1_adv)
        begin
            s2_h_reg <= hash_tail(s1_h_reg, s1_tail_reg);
        end
    end

    assign hash_valid = s2_v_reg;
    assign hash_data  = s2_h_reg;

endmodule

// File: sv/fcms_queue.sv
// ----------------------------------------------------------------------------
// fcms_queue
// two-entry queue of partial hashes between front and back
// ----------------------------------------------------------------------------
module fcms_queue
    import fcms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_data
);

    logic [31:0] mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        wr, rd;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign wr        = in_valid && in_ready;
    assign rd        = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, wr} - {1'b0, rd};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// File: sv/fcms_back.sv
// ----------------------------------------------------------------------------
// fcms_back
// per-row bucket select, counter read-modify-write and result queue
// ----------------------------------------------------------------------------
module fcms_back
    import fcms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        hash_valid,
    output logic        hash_ready,
    input  logic [31:0] hash_data,
    output logic        busy,
    output logic        empty,
    input  logic        pop,
    output result_t     head
);

    logic [31:0]       mem [DEPTH];
    logic [31:0]       rdata_reg;

    logic              clr_reg, clr_next;
    logic [ADDR_W-1:0] clr_addr_reg, clr_addr_next;

    row_t              row_reg, row_next;
    logic              p_v_reg;
    row_t              p_row_reg;
    logic [BKT_W-1:0]  p_bkt_reg;
    logic [ADDR_W-1:0] p_addr_reg;
    logic              fwd_reg;
    logic [31:0]       fwd_data_reg;

    result_t           fifo_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wp_reg, rp_reg;
    logic [OUT_CNT_W-1:0] cnt_reg, cnt_next;

    logic [31:0]       h14, h15, old_cnt, new_cnt;
    logic [BKT_W-1:0]  bkt;
    logic [ADDR_W-1:0] addr;
    logic              issue, last, do_pop;
    result_t           res;

    assign h14  = (hash_data << 5) + hash_data + 32'(row_reg);
    assign h15  = (h14 << 5) + h14;
    assign bkt  = BKT_W'(h15 % ROW_WIDTH);
    assign addr = ADDR_W'(row_reg) * ADDR_W'(ROW_WIDTH) + ADDR_W'(bkt);
    assign last = (row_reg == row_t'(ROWS - 1));

    assign issue      = hash_valid && !clr_reg
                        && ((cnt_reg + OUT_CNT_W'(p_v_reg)) < OUT_CNT_W'(OUT_DEPTH));
    assign hash_ready = issue && last;
    assign busy       = clr_reg;

    assign old_cnt = fwd_reg ? fwd_data_reg : rdata_reg;
    assign new_cnt = (old_cnt == 32'hFFFF_FFFF) ? old_cnt : old_cnt + 32'd1;

    always_comb
    begin
        res.row_number   = 4'(p_row_reg);
        res.bucket_index = 16'(p_bkt_reg);
        res.new_count    = new_cnt;
        res.last_row     = (p_row_reg == row_t'(ROWS - 1));
    end

    assign empty  = (cnt_reg == '0);
    assign head   = fifo_reg[rp_reg];
    assign do_pop = pop && !empty;

    always_comb
    begin
        clr_next      = clr_reg;
        clr_addr_next = clr_addr_reg;
        if (clr_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clr_next = 1'b0;
            end
        end
        row_next = row_reg;
        if (issue)
        begin
            row_next = last ? '0 : row_reg + 1'b1;
        end
        cnt_next = cnt_reg + OUT_CNT_W'(p_v_reg) - OUT_CNT_W'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= 1'b1;
            clr_addr_reg <= '0;
            row_reg      <= '0;
            p_v_reg      <= 1'b0;
            fwd_reg      <= 1'b0;
            wp_reg       <= '0;
            rp_reg       <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            clr_reg      <= clr_next;
            clr_addr_reg <= clr_addr_next;
            row_reg      <= row_next;
            p_v_reg      <= issue;
            fwd_reg      <= issue && p_v_reg && (addr == p_addr_reg);
            cnt_reg      <= cnt_next;
            if (p_v_reg)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (do_pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            p_row_reg  <= row_reg;
            p_bkt_reg  <= bkt;
            p_addr_reg <= addr;
        end
        fwd_data_reg <= new_cnt;
        if (p_v_reg)
        begin
            fifo_reg[wp_reg] <= res;
        end
    end

    // counter memory: one read and one write port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[addr];
        if (clr_reg)
        begin
            mem[clr_addr_reg] <= 32'd0;
        end
        else if (p_v_reg)
        begin
            mem[p_addr_reg] <= new_cnt;
        end
    end

`ifndef SYNTHESIS
    a_no_work_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_reg |-> !p_v_reg)
        else $error("row update during clearing pass");
    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= OUT_CNT_W'(OUT_DEPTH))
        else $error("result queue overflow");
    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        p_v_reg |-> (new_cnt != 32'd0))
        else $error("updated counter reads zero");
    a_row_wraps_with_pop: assert property (@(posedge clk) disable iff (!rst_n)
        hash_ready |=> (row_reg == '0))
        else $error("row counter not reset after last row");
`endif

endmodule

// File: sv/flow_count_min_sketch_update.sv
// ----------------------------------------------------------------------------
// flow_count_min_sketch_update
// count-min sketch update of tcp/udp ipv4 flows, djb2 hash per row
// ----------------------------------------------------------------------------
// channel   direction  handshake         payload
// input     in         push / full       is_ipv4, addresses, ports, ip_proto
// result    out        pop / empty       row_number, bucket_index, new_count, last_row
//
// each counted item does one counter read-modify-write per row, ROWS (4) rows,
// on the single counter memory; dropped items never reach the counter memory
// after reset full stays high while all ROWS*ROW_WIDTH (4096) counters clear
// front hashing is registered in stages s1 and s2; a two-entry queue decouples it from
// the back, and a four-entry result queue absorbs stalls on pop
// ----------------------------------------------------------------------------
module flow_count_min_sketch_update
    import fcms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        is_ipv4,
    input  logic [31:0] src_addr,
    input  logic [31:0] dst_addr,
    input  logic [15:0] src_port_num,
    input  logic [15:0] dst_port_num,
    input  logic [7:0]  ip_proto,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  row_number,
    output logic [15:0] bucket_index,
    output logic [31:0] new_count,
    output logic        last_row
);

    logic        f_valid, f_ready, b_valid, b_ready, busy;
    logic [31:0] f_data, b_data;
    result_t     head;

    fcms_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .is_ipv4      (is_ipv4),
        .src_addr     (src_addr),
        .dst_addr     (dst_addr),
        .src_port_num (src_port_num),
        .dst_port_num (dst_port_num),
        .ip_proto     (ip_proto),
        .busy         (busy),
        .hash_valid   (f_valid),
        .hash_ready   (f_ready),
        .hash_data    (f_data)
    );

    fcms_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (b_data)
    );

    fcms_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .hash_valid (b_valid),
        .hash_ready (b_ready),
        .hash_data  (b_data),
        .busy       (busy),
        .empty      (empty),
        .pop        (pop),
        .head       (head)
    );

    assign row_number   = head.row_number;
    assign bucket_index = head.bucket_index;
    assign new_count    = head.new_count;
    assign last_row     = head.last_row;

endmodule

// File: sim/sketch_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sketch_checker
// watches the item and result channels, predicts sketch counter updates and
// compares each popped result field by field against the oldest prediction
// ----------------------------------------------------------------------------
module sketch_checker
    import fcms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic        is_ipv4,
    input  logic [31:0] src_addr,
    input  logic [31:0] dst_addr,
    input  logic [15:0] src_port_num,
    input  logic [15:0] dst_port_num,
    input  logic [7:0]  ip_proto,
    input  logic        empty,
    input  logic        pop,
    input  logic [3:0]  row_number,
    input  logic [15:0] bucket_index,
    input  logic [31:0] new_count,
    input  logic        last_row,
    output int          fail_count,
    output int          pending
);

    logic [31:0] counters [DEPTH];
    result_t     expected_updates [$];

    assign pending = expected_updates.size();

    function automatic logic [31:0] flow_hash(input logic [103:0] tuple, input int row);
        logic [119:0] key;
        logic [31:0]  h;
        key = {tuple, row[7:0], 8'd0};
        h = 32'd5381;
        for (int i = 0; i < 15; i++)
        begin
            h = h * 33 + {24'd0, key[119 - 8*i -: 8]};
        end
        return h;
    endfunction

    task automatic count_flow();
        logic [31:0] h;
        int          bkt;
        int          slot;
        result_t     r;
        if (!is_ipv4 || (ip_proto != PROTO_TCP && ip_proto != PROTO_UDP))
        begin
            return;
        end
        for (int row = 0; row < ROWS; row++)
        begin
            h = flow_hash({src_addr, dst_addr, src_port_num, dst_port_num, ip_proto}, row);
            bkt = h % ROW_WIDTH;
            slot = row * ROW_WIDTH + bkt;
            if (counters[slot] != 32'hFFFF_FFFF)
            begin
                counters[slot] = counters[slot] + 1;
            end
            r.row_number   = row[3:0];
            r.bucket_index = bkt[15:0];
            r.new_count    = counters[slot];
            r.last_row     = (row == ROWS - 1);
            expected_updates.push_back(r);
        end
    endtask

    task automatic check_result();
        result_t e;
        if (expected_updates.size() == 0)
        begin
            $error("result with no item pending: row %0d", row_number);
            fail_count++;
            return;
        end
        e = expected_updates.pop_front();
        if (row_number !== e.row_number)
        begin
            $error("row_number expected %0d actual %0d", e.row_number, row_number);
            fail_count++;
        end
        if (bucket_index !== e.bucket_index)
        begin
            $error("bucket_index expected %0d actual %0d", e.bucket_index, bucket_index);
            fail_count++;
        end
        if (new_count !== e.new_count)
        begin
            $error("new_count expected %0d actual %0d", e.new_count, new_count);
            fail_count++;
        end
        if (last_row !== e.last_row)
        begin
            $error("last_row expected %0d actual %0d", e.last_row, last_row);
            fail_count++;
        end
    endtask

    initial
    begin
        fail_count = 0;
        foreach (counters[i]) counters[i] = '0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                check_result();
            end
            if (push && !full)
            begin
                count_flow();
            end
        end
    end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives directed and random flow tuples into the sketch update with random
// gaps and result stalls; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module tb_top;
    import fcms_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        is_ipv4;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port_num;
    logic [15:0] dst_port_num;
    logic [7:0]  ip_proto;
    logic        empty;
    logic        pop;
    logic [3:0]  row_number;
    logic [15:0] bucket_index;
    logic [31:0] new_count;
    logic        last_row;
    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_idle_pct;
    logic [103:0] flow_pool [8];

    flow_count_min_sketch_update u_top (.*);

    sketch_checker u_checker (.*);

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // receiver stalls at random
    always @(posedge clk)
    begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_flow(input logic v4, input logic [103:0] t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        is_ipv4 <= v4;
        {src_addr, dst_addr, src_port_num, dst_port_num, ip_proto} <= t;
        @(posedge clk);
        while (full)
        begin
            @(posedge clk);
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    function automatic logic [103:0] random_flow(input logic [7:0] proto);
        return {$urandom, $urandom, 16'($urandom), 16'($urandom), proto};
    endfunction

    function automatic logic [7:0] pick_proto();
        int k;
        k = $urandom_range(9);
        if (k < 5) return PROTO_TCP;
        if (k < 9) return PROTO_UDP;
        return 8'($urandom);
    endfunction

    initial
    begin
        logic [103:0] t;
        push = 1'b0;
        is_ipv4 = 1'b0;
        {src_addr, dst_addr, src_port_num, dst_port_num, ip_proto} = '0;
        send_idle_pct = 8;
        recv_idle_pct = 82;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_flow(1'b1, {32'd0, 32'd0, 16'd0, 16'd0, PROTO_TCP});
        send_flow(1'b1, {32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, PROTO_UDP});
        send_flow(1'b1, {32'd0, 32'd0, 16'd0, 16'd0, PROTO_TCP});
        send_flow(1'b0, {32'h0A00_0001, 32'h0A00_0002, 16'd80, 16'd443, PROTO_TCP});
        send_flow(1'b1, {32'h0A00_0001, 32'h0A00_0002, 16'd80, 16'd443, 8'd1});
        send_flow(1'b1, {32'h0A00_0001, 32'h0A00_0002, 16'd80, 16'd443, 8'hFF});
        send_flow(1'b1, {32'h0A00_0001, 32'h0A00_0002, 16'd80, 16'd443, 8'd0});
        send_flow(1'b1, {32'hC0A8_0101, 32'h0808_0808, 16'd5353, 16'd53, PROTO_UDP});
        send_flow(1'b1, {32'hC0A8_0101, 32'h0808_0808, 16'd5353, 16'd53, PROTO_UDP});
        drain();
        foreach (flow_pool[i]) flow_pool[i] = random_flow($urandom_range(1) ? PROTO_TCP : PROTO_UDP);
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 82 : 0;
            recv_idle_pct = (phase == 0) ? 82 : (phase == 1) ? 8 : 0;
            for (int n = 0; n < 44; n++)
            begin
                // repeated flows drive counters up
                if ($urandom_range(2) == 0)
                    t = flow_pool[$urandom_range(7)];
                else
                    t = random_flow(pick_proto());
                send_flow($urandom_range(9) != 0, t);
            end
            drain();
        end
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial
    begin
        #10ms;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

// File: sim.f
sv/fcms_pkg.sv
sv/fcms_front.sv
sv/fcms_queue.sv
sv/fcms_back.sv
sv/flow_count_min_sketch_update.sv
sim/sketch_checker.sv
sim/tb_top.sv
